// File: src/paq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paq_pkg
// Shared types and constants of the priority admission queue.
// ----------------------------------------------------------------------------
package paq_pkg;

   localparam int KIND_W  = 1;
   localparam int PRIO_W  = 8;
   localparam int IDENT_W = 16;
   localparam int OCC_W   = 12;
   localparam int WAIT_W  = 7;

   localparam logic [KIND_W-1:0] KIND_ARRIVAL   = 1'b0;
   localparam logic [KIND_W-1:0] KIND_DEPARTURE = 1'b1;

   localparam logic [OCC_W-1:0] CAPACITY_RESET = 12'd16;

   // one waiting entry
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [IDENT_W-1:0] ident;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type item;
   } ctl_type;

endpackage
`default_nettype wire

// File: src/paq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paq_if
// Valid/ready channels of the priority admission queue.
// ----------------------------------------------------------------------------
interface paq_req_if;
   import paq_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [PRIO_W-1:0]   priority_req;
   logic [IDENT_W-1:0]  ident;
   modport source(output valid, kind, priority_req, ident, input ready);
   modport sink(input valid, kind, priority_req, ident, output ready);
endinterface

interface paq_rsp_if;
   import paq_pkg::*;
   logic                valid;
   logic                ready;
   logic                admitted;
   logic [IDENT_W-1:0]  admitted_ident;
   logic                queued;
   logic                dropped_full;
   logic                underflow_error;
   logic [OCC_W-1:0]    occupancy;
   logic [WAIT_W-1:0]   waiting;
   modport source(output valid, admitted, admitted_ident, queued, dropped_full,
                  underflow_error, occupancy, waiting, input ready);
   modport sink(input valid, admitted, admitted_ident, queued, dropped_full,
                underflow_error, occupancy, waiting, output ready);
endinterface

interface paq_csr_if;
   import paq_pkg::*;
   logic              valid;
   logic              ready;
   logic [OCC_W-1:0]  data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// File: src/paq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paq_cell
// One slot of the sorted waiting list: holds an entry, keeps it, takes the
// new item or shifts in from a neighbor.
// ----------------------------------------------------------------------------
module paq_cell (
   input  wire logic                clock,
   input  wire paq_pkg::ctl_type    ctl,
   input  wire logic                occupied,
   input  wire paq_pkg::entry_type  left_entry,
   input  wire logic                left_keep,
   input  wire paq_pkg::entry_type  right_entry,
   output paq_pkg::entry_type       entry,
   output logic                     keep
);
   import paq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // sorted list: keep is a prefix, equal priorities stay ahead (stable)
   assign keep  = occupied && (entry_ff.prio <= ctl.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = right_entry;
      end else if (ctl.insert && !keep) begin
         entry_in = left_keep ? ctl.item : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// File: src/priority_admission_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_admission_queue
// Admission control with a stable priority-sorted waiting list.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  : arrival (kind 0, priority_req, ident) or departure (kind 1).
//   rsp_ch  : one result item per request: admitted / admitted_ident,
//             queued, dropped_full, underflow_error, occupancy, waiting.
//   csr_ch  : capacity write, always ready; write only while idle.
// The result is valid in the cycle after request acceptance. Throughput is
// one item per cycle while the receiver keeps up: the waiting list is a chain
// of QUEUE_DEPTH cells that compare against the new priority in parallel and
// shift by one slot together, for insert as well as for head removal.
// The result sits in an output register; a new request is taken whenever
// that register is empty or is being drained in the same cycle. If the
// receiver stalls, req_ch.ready drops after one item and nothing is lost.
// Reset (synchronous, active high) empties the list, clears occupancy and
// sets capacity to 16. Slot contents are not reset; only slots below the
// fill count are ever looked at.
// ----------------------------------------------------------------------------
module priority_admission_queue #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   paq_req_if.sink    req_ch,
   paq_rsp_if.source  rsp_ch,
   paq_csr_if.sink    csr_ch
);
   import paq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [OCC_W-1:0]   capacity_ff;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               rsp_valid_ff;
   logic               adm_ff, adm_in;
   logic [IDENT_W-1:0] adm_id_ff, adm_id_in;
   logic               queued_ff, queued_in;
   logic               drop_ff, drop_in;
   logic               under_ff, under_in;

   logic               accept;
   logic               arrive;
   logic               list_full;
   ctl_type            ctl;
   entry_type          entries [QUEUE_DEPTH];
   logic               keeps   [QUEUE_DEPTH];
   logic [CW+WAIT_W-1:0] wait_wide;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign arrive       = (req_ch.kind == KIND_ARRIVAL);
   assign list_full    = (count_ff == CW'(QUEUE_DEPTH));

   always_comb begin
      occ_in      = occ_ff;
      count_in    = count_ff;
      adm_in      = 1'b0;
      adm_id_in   = '0;
      queued_in   = 1'b0;
      drop_in     = 1'b0;
      under_in    = 1'b0;
      ctl.insert  = 1'b0;
      ctl.pop     = 1'b0;
      ctl.item.prio  = req_ch.priority_req;
      ctl.item.ident = req_ch.ident;
      if (accept) begin
         if (arrive) begin
            if (occ_ff < capacity_ff) begin
               occ_in    = occ_ff + 1'b1;
               adm_in    = 1'b1;
               adm_id_in = req_ch.ident;
            end else if (!list_full) begin
               ctl.insert = 1'b1;
               count_in   = count_ff + 1'b1;
               queued_in  = 1'b1;
            end else begin
               drop_in = 1'b1;
            end
         end else begin
            if (occ_ff == '0) begin
               under_in = 1'b1;
            end else if (occ_ff == capacity_ff && count_ff != '0) begin
               // a seat frees up at exactly full: the head takes it
               ctl.pop   = 1'b1;
               count_in  = count_ff - 1'b1;
               adm_in    = 1'b1;
               adm_id_in = entries[0].ident;
            end else begin
               occ_in = occ_ff - 1'b1;
            end
         end
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_k;
      logic      occupied;

      assign occupied = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign left_e = ctl.item;
         assign left_k = 1'b1;
      end else begin : g_link
         assign left_e = entries[i-1];
         assign left_k = keeps[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = entries[i];
      end else begin : g_next
         assign right_e = entries[i+1];
      end

      paq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .right_entry (right_e),
         .entry       (entries[i]),
         .keep        (keeps[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            capacity_ff <= csr_ch.data;
         end
         occ_ff   <= occ_in;
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         adm_ff    <= adm_in;
         adm_id_ff <= adm_id_in;
         queued_ff <= queued_in;
         drop_ff   <= drop_in;
         under_ff  <= under_in;
      end
   end

   // waiting count is reported modulo 128
   assign wait_wide = {{WAIT_W{1'b0}}, count_ff};

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.admitted        = adm_ff;
   assign rsp_ch.admitted_ident  = adm_id_ff;
   assign rsp_ch.queued          = queued_ff;
   assign rsp_ch.dropped_full    = drop_ff;
   assign rsp_ch.underflow_error = under_ff;
   assign rsp_ch.occupancy       = occ_ff;
   assign rsp_ch.waiting         = wait_wide[WAIT_W-1:0];

endmodule
`default_nettype wire

// File: src/paq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paq_checker
// Port-level checks of the priority admission queue.
// ----------------------------------------------------------------------------
module paq_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    admitted,
   input wire logic [paq_pkg::IDENT_W-1:0] admitted_ident,
   input wire logic                    queued,
   input wire logic                    dropped_full,
   input wire logic                    underflow_error
);
   import paq_pkg::*;

   // every accepted request yields a result in the next cycle
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted request");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(admitted_ident))
      else $error("stalled result changed");

   // one outcome per item at most
   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({admitted, queued, dropped_full, underflow_error}))
      else $error("conflicting outcome flags");

   a_ident_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !admitted |-> admitted_ident == '0)
      else $error("ident set without admission");

endmodule

bind priority_admission_queue paq_checker u_paq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .admitted        (rsp_ch.admitted),
   .admitted_ident  (rsp_ch.admitted_ident),
   .queued          (rsp_ch.queued),
   .dropped_full    (rsp_ch.dropped_full),
   .underflow_error (rsp_ch.underflow_error)
);
`default_nettype wire
